/* sv/ttce_pkg.sv */
// Package with the shared types, codes and defaults of the text terminal cursor engine.
`timescale 1ns / 1ps

package ttce_pkg;

    localparam int COLS_DEFAULT      = 80;
    localparam int ROWS_DEFAULT      = 25;
    localparam int TAB_WIDTH_DEFAULT = 4;
    localparam int MAX_RESULTS       = 6;

    localparam int LINE_END_W = 8;
    localparam logic [LINE_END_W-1:0] NO_END = 8'hFF;

    localparam logic [7:0] ATTR_RESET = 8'd7;

    localparam logic [1:0] OP_PUT       = 2'd0;
    localparam logic [1:0] OP_BACKSPACE = 2'd1;
    localparam logic [1:0] OP_CLEAR     = 2'd2;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_SCROLL = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_CURSOR = 2'd3;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] glyph;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] column;
        logic [4:0] row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       last;
    } res_t;

endpackage

/* sv/text_terminal_cursor_engine.sv */
// Top level of the text terminal cursor engine: command sequencer, cursor and line-end table.
//
//   Channel   Signals                          Direction   Transaction
//   cmd       cmd_valid, cmd_stall, cmd        in          one terminal command
//   res       res_valid, res_stall, res        out         one result (cell, scroll, clear, cursor)
//   cfg       cfg_write_en, cfg_write_data     in          attribute register write
//
// A plain character passes accept, cell write, wrap check and cursor result in turn.
// A tab repeats cell write and wrap check per padding space; a wrap adds a scroll check.
// A newline adds a line-end write and scroll check; a return goes straight to the cursor result.
// A backspace erases a cell (reading the line end across a row); a clear emits a clear result.
// Reset clears the cursor, sets every line end to no end and the attribute to 7.
// A stalled result register holds the sequencer in each emitting state until that transaction completes.
`timescale 1ns / 1ps

module text_terminal_cursor_engine #(
    parameter int COLS      = ttce_pkg::COLS_DEFAULT,
    parameter int ROWS      = ttce_pkg::ROWS_DEFAULT,
    parameter int TAB_WIDTH = ttce_pkg::TAB_WIDTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  ttce_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output ttce_pkg::res_t res,
    input  logic           cfg_write_en,
    input  logic [7:0]     cfg_write_data
);

    localparam int CW  = $clog2(COLS + 1);
    localparam int CIW = $clog2(COLS);
    localparam int RW  = $clog2(ROWS + 1);
    localparam int RIW = $clog2(ROWS);
    localparam int PW  = $clog2(TAB_WIDTH + 1);
    localparam int NW  = $clog2(ttce_pkg::MAX_RESULTS);
    localparam int LW  = ttce_pkg::LINE_END_W;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_PUT     = 9'b000000010,
        ST_WRAP    = 9'b000000100,
        ST_SCROLL  = 9'b000001000,
        ST_NEWLINE = 9'b000010000,
        ST_BSROW   = 9'b000100000,
        ST_ERASE   = 9'b001000000,
        ST_CLEAR   = 9'b010000000,
        ST_CURSOR  = 9'b100000000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [PW-1:0]  pad_cnt_reg, pad_cnt_next;
    logic [NW-1:0]  emit_cnt_reg, emit_cnt_next;
    logic [7:0]     char_reg, char_next;
    logic [7:0]     attr_reg;
    logic [LW-1:0]  line_end_reg [ROWS];
    logic [LW-1:0]  line_end_next [ROWS];
    logic           res_valid_reg, res_valid_next;
    ttce_pkg::res_t res_reg, res_next;

    logic [PW-1:0]  pad_rom [COLS];
    logic           out_free;
    logic           keep;
    logic           le_wr;
    logic           le_shift;
    logic [LW-1:0]  le_wr_data;
    logic [LW-1:0]  le_cur;
    logic [CW-1:0]  col_inc;

    // Padding needed from each column to the next tab stop.
    for (genvar g = 0; g < COLS; g++)
    begin : g_pad
        assign pad_rom[g] = PW'(TAB_WIDTH - (g % TAB_WIDTH));
    end

    assign out_free  = !res_valid_reg || !res_stall;
    assign keep      = emit_cnt_reg < NW'(ttce_pkg::MAX_RESULTS - 1);
    assign le_cur    = line_end_reg[row_reg[RIW-1:0]];
    assign col_inc   = col_reg + 1'b1;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pad_cnt_next  = pad_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        char_next     = char_reg;
        le_wr         = 1'b0;
        le_shift      = 1'b0;
        le_wr_data    = ttce_pkg::NO_END;
        res_next      = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    emit_cnt_next = '0;
                    pad_cnt_next  = '0;
                    case (cmd.operation)
                        ttce_pkg::OP_PUT:
                        begin
                            if (cmd.glyph == ttce_pkg::CH_NEWLINE)
                            begin
                                state_next = ST_NEWLINE;
                            end
                            else if (cmd.glyph == ttce_pkg::CH_TAB)
                            begin
                                char_next    = ttce_pkg::CH_SPACE;
                                pad_cnt_next = pad_rom[col_reg[CIW-1:0]];
                                state_next   = ST_PUT;
                            end
                            else if (cmd.glyph == ttce_pkg::CH_RETURN)
                            begin
                                col_next   = '0;
                                state_next = ST_CURSOR;
                            end
                            else
                            begin
                                char_next    = cmd.glyph;
                                pad_cnt_next = PW'(1);
                                state_next   = ST_PUT;
                            end
                        end
                        ttce_pkg::OP_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next   = col_reg - 1'b1;
                                state_next = ST_ERASE;
                            end
                            else if (row_reg != '0)
                            begin
                                row_next   = row_reg - 1'b1;
                                state_next = ST_BSROW;
                            end
                        end
                        ttce_pkg::OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                if (!keep || out_free)
                begin
                    if (keep)
                    begin
                        res_next.action    = ttce_pkg::ACT_WRITE;
                        res_next.column    = 7'(col_reg);
                        res_next.row       = 5'(row_reg);
                        res_next.cell_char = char_reg;
                        res_next.cell_attr = attr_reg;
                        res_next.last      = 1'b0;
                        res_valid_next     = 1'b1;
                        emit_cnt_next      = emit_cnt_reg + 1'b1;
                    end
                    col_next     = col_inc;
                    pad_cnt_next = pad_cnt_reg - 1'b1;
                    state_next   = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (col_reg == CW'(COLS))
                begin
                    le_wr      = 1'b1;
                    le_wr_data = LW'(COLS - 1);
                    row_next   = row_reg + 1'b1;
                    col_next   = '0;
                    state_next = ST_SCROLL;
                end
                else if (pad_cnt_reg != '0)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    state_next = ST_CURSOR;
                end
            end
            ST_SCROLL:
            begin
                if (row_reg == RW'(ROWS))
                begin
                    if (!keep || out_free)
                    begin
                        if (keep)
                        begin
                            res_next.action    = ttce_pkg::ACT_SCROLL;
                            res_next.column    = '0;
                            res_next.row       = '0;
                            res_next.cell_char = ttce_pkg::CH_SPACE;
                            res_next.cell_attr = attr_reg;
                            res_next.last      = 1'b0;
                            res_valid_next     = 1'b1;
                            emit_cnt_next      = emit_cnt_reg + 1'b1;
                        end
                        le_shift   = 1'b1;
                        row_next   = RW'(ROWS - 1);
                        col_next   = '0;
                        state_next = (pad_cnt_reg != '0) ? ST_PUT : ST_CURSOR;
                    end
                end
                else
                begin
                    state_next = (pad_cnt_reg != '0) ? ST_PUT : ST_CURSOR;
                end
            end
            ST_NEWLINE:
            begin
                le_wr      = 1'b1;
                le_wr_data = (col_reg != '0) ? LW'(col_reg - 1'b1) : ttce_pkg::NO_END;
                col_next   = '0;
                row_next   = row_reg + 1'b1;
                state_next = ST_SCROLL;
            end
            ST_BSROW:
            begin
                if (le_cur == ttce_pkg::NO_END)
                begin
                    col_next = '0;
                end
                else if (le_cur >= LW'(COLS - 1))
                begin
                    col_next = CW'(COLS - 1);
                end
                else
                begin
                    col_next = CW'(le_cur + 1'b1);
                end
                state_next = ST_ERASE;
            end
            ST_ERASE:
            begin
                if (out_free)
                begin
                    res_next.action    = ttce_pkg::ACT_WRITE;
                    res_next.column    = 7'(col_reg);
                    res_next.row       = 5'(row_reg);
                    res_next.cell_char = ttce_pkg::CH_SPACE;
                    res_next.cell_attr = attr_reg;
                    res_next.last      = 1'b0;
                    res_valid_next     = 1'b1;
                    state_next         = ST_CURSOR;
                end
            end
            ST_CLEAR:
            begin
                if (out_free)
                begin
                    res_next.action    = ttce_pkg::ACT_CLEAR;
                    res_next.column    = '0;
                    res_next.row       = '0;
                    res_next.cell_char = ttce_pkg::CH_SPACE;
                    res_next.cell_attr = attr_reg;
                    res_next.last      = 1'b0;
                    res_valid_next     = 1'b1;
                    state_next         = ST_CURSOR;
                end
            end
            ST_CURSOR:
            begin
                if (out_free)
                begin
                    res_next.action    = ttce_pkg::ACT_CURSOR;
                    res_next.column    = 7'(col_reg);
                    res_next.row       = 5'(row_reg);
                    res_next.cell_char = '0;
                    res_next.cell_attr = '0;
                    res_next.last      = 1'b1;
                    res_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            line_end_next[r] = line_end_reg[r];
        end
        if (le_shift)
        begin
            for (int r = 0; r < ROWS - 1; r++)
            begin
                line_end_next[r] = line_end_reg[r + 1];
            end
            line_end_next[ROWS - 1] = ttce_pkg::NO_END;
        end
        else if (le_wr)
        begin
            line_end_next[row_reg[RIW-1:0]] = le_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            pad_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
            attr_reg      <= ttce_pkg::ATTR_RESET;
            for (int r = 0; r < ROWS; r++)
            begin
                line_end_reg[r] <= ttce_pkg::NO_END;
            end
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pad_cnt_reg   <= pad_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write_en)
            begin
                attr_reg <= cfg_write_data;
            end
            for (int r = 0; r < ROWS; r++)
            begin
                line_end_reg[r] <= line_end_next[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        res_reg  <= res_next;
    end

    // The cursor rests inside the screen whenever a new command can be taken.
    a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> col_reg < CW'(COLS) && row_reg < RW'(ROWS))
        else $error("cursor outside the screen while idle");

    // The number of cell and scroll results never passes the limit for one command.
    a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= NW'(ttce_pkg::MAX_RESULTS - 1))
        else $error("too many results for one command");

    // A character is written only while padding remains.
    a_put_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUT |-> pad_cnt_reg != '0)
        else $error("cell write with no padding left");

    // The row passes the bottom by at most one and only before the scroll check.
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg == RW'(ROWS) |-> state_reg == ST_SCROLL)
        else $error("row beyond the screen outside the scroll check");

    // A completed cursor transaction marks the last result of the command.
    a_cursor_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.action == ttce_pkg::ACT_CURSOR |-> res_reg.last)
        else $error("cursor result without the last flag");

endmodule
